### hdl/asn1hdr_pkg.sv
// Shared types and constants for the DER tag/length header parser.
`default_nettype none
package asn1hdr_pkg;

  // Size limits of the identifier, length and INTEGER fields
  localparam int unsigned MAX_TAG_OCTETS    = 5;
  localparam int unsigned MAX_LENGTH_OCTETS = 4;
  localparam int unsigned MAX_INT_OCTETS    = 4;

  // Identifier octet values
  localparam logic [4:0] TAG_HIGH_FORM   = 5'h1F;
  localparam logic [31:0] TAG_INTEGER    = 32'd2;
  localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;

  // Length octets that are never valid in DER
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;
  localparam logic [7:0] LEN_RESERVED   = 8'hFF;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_ENCODING  = 3'd2;
  localparam logic [2:0] ST_CLASS     = 3'd3;
  localparam logic [2:0] ST_TYPE      = 3'd4;

  // Parse phases, one-hot
  typedef enum logic [5:0] {
    PH_IDENT = 6'b000001,
    PH_TAG   = 6'b000010,
    PH_LEN0  = 6'b000100,
    PH_LENL  = 6'b001000,
    PH_BODY  = 6'b010000,
    PH_SKIP  = 6'b100000
  } phase_e;

  // One input transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One header result
  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         tag_class;
    logic               is_constructed;
    logic [31:0]        tag_number;
    logic [31:0]        content_length;
    logic [3:0]         header_length;
    logic signed [31:0] int_value;
  } out_t;

  // Parser state carried from octet to octet
  typedef struct packed {
    phase_e      phase;
    logic [1:0]  class_bits;
    logic        constructed;
    logic [31:0] tag_acc;
    logic [2:0]  octet_cnt;
    logic [31:0] len_acc;
    logic [31:0] remaining;
    logic [3:0]  hdr_cnt;
    logic [31:0] int_acc;
  } state_t;

endpackage
`default_nettype wire

### hdl/asn1hdr_step.sv
// Per-octet next-state and result logic of the DER header parser.
`default_nettype none
module asn1hdr_step (
  input  asn1hdr_pkg::state_t state_i,
  input  asn1hdr_pkg::in_t    in_i,
  input  logic                expect_integer_i,
  output asn1hdr_pkg::state_t state_o,
  output logic                res_valid_o,
  output asn1hdr_pkg::out_t   res_o
);
  import asn1hdr_pkg::*;

  logic [7:0]  b;
  logic        last;
  logic        do_fail;
  logic        do_finish;
  logic        do_start;
  logic [2:0]  fin_status;
  logic [31:0] fin_value;
  logic [2:0]  status;
  logic [31:0] value;
  state_t      nxt;

  assign b    = in_i.data_byte;
  assign last = in_i.last_byte;

  always_comb begin
    nxt        = state_i;
    do_fail    = 1'b0;
    do_finish  = 1'b0;
    do_start   = 1'b0;
    fin_status = ST_OK;
    fin_value  = '0;
    status     = ST_OK;
    value      = '0;

    // Phase-specific update
    unique case (state_i.phase)
      PH_TAG: begin
        nxt.hdr_cnt   = state_i.hdr_cnt + 4'd1;
        nxt.octet_cnt = state_i.octet_cnt + 3'd1;
        nxt.tag_acc   = {state_i.tag_acc[24:0], b[6:0]};
        if (b[7]) begin
          if (nxt.octet_cnt >= 3'(MAX_TAG_OCTETS)) begin
            do_fail = 1'b1;
          end else if (last) begin
            do_fail = 1'b1;
          end
        end else begin
          nxt.phase = PH_LEN0;
          if (last) do_fail = 1'b1;
        end
      end
      PH_LEN0: begin
        nxt.hdr_cnt = state_i.hdr_cnt + 4'd1;
        if (!b[7]) begin
          nxt.len_acc = {24'd0, b};
          do_start    = 1'b1;
        end else if (b == LEN_INDEFINITE || b == LEN_RESERVED) begin
          do_fail = 1'b1;
        end else if (b[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
          do_fail = 1'b1;
        end else begin
          nxt.octet_cnt = b[2:0];
          nxt.phase     = PH_LENL;
          if (last) do_fail = 1'b1;
        end
      end
      PH_LENL: begin
        nxt.hdr_cnt = state_i.hdr_cnt + 4'd1;
        nxt.len_acc = {state_i.len_acc[23:0], b};
        if (state_i.octet_cnt != 3'd0) nxt.octet_cnt = state_i.octet_cnt - 3'd1;
        if (nxt.octet_cnt == 3'd0) begin
          do_start = 1'b1;
        end else if (last) begin
          do_fail = 1'b1;
        end
      end
      PH_BODY: begin
        if (state_i.remaining == state_i.len_acc) begin
          nxt.int_acc = {{24{b[7]}}, b};
        end else begin
          nxt.int_acc = {state_i.int_acc[23:0], b};
        end
        if (state_i.remaining != 32'd0) nxt.remaining = state_i.remaining - 32'd1;
        if (nxt.remaining == 32'd0) begin
          do_finish = 1'b1;
        end else if (last) begin
          do_fail = 1'b1;
        end
      end
      PH_SKIP: begin
        if (last) nxt.phase = PH_IDENT;
      end
      default: begin
        // Identifier octet; unused phase codes land here too
        nxt.class_bits  = b[7:6];
        nxt.constructed = b[5];
        nxt.tag_acc     = '0;
        nxt.len_acc     = '0;
        nxt.remaining   = '0;
        nxt.int_acc     = '0;
        nxt.octet_cnt   = '0;
        nxt.hdr_cnt     = 4'd1;
        if (b[4:0] != TAG_HIGH_FORM) begin
          nxt.tag_acc = {27'd0, b[4:0]};
          nxt.phase   = PH_LEN0;
        end else begin
          nxt.phase = PH_TAG;
        end
        if (last) do_fail = 1'b1;
      end
    endcase

    // Length complete: begin counting contents
    if (do_start) begin
      nxt.remaining = nxt.len_acc;
      if (nxt.len_acc == 32'd0) begin
        do_finish = 1'b1;
      end else begin
        nxt.phase = PH_BODY;
        if (last) do_fail = 1'b1;
      end
    end

    // Item complete: optional INTEGER checks
    if (expect_integer_i) begin
      if (nxt.constructed) begin
        fin_status = ST_ENCODING;
      end else if (nxt.class_bits != CLASS_UNIVERSAL) begin
        fin_status = ST_CLASS;
      end else if (nxt.tag_acc != TAG_INTEGER) begin
        fin_status = ST_TYPE;
      end else if (nxt.len_acc == 32'd0 || nxt.len_acc > 32'(MAX_INT_OCTETS)) begin
        fin_status = ST_TRUNCATED;
      end else begin
        fin_value = nxt.int_acc;
      end
    end

    if (do_fail) begin
      status = ST_TRUNCATED;
    end else if (do_finish) begin
      status = fin_status;
      value  = fin_value;
    end

    // Any result sends the parser back to an identifier, or to skip on an error not at last_byte
    if (do_fail || do_finish) begin
      if (status != ST_OK && !last) begin
        nxt.phase = PH_SKIP;
      end else begin
        nxt.phase = PH_IDENT;
      end
    end
  end

  assign state_o     = nxt;
  assign res_valid_o = do_fail | do_finish;

  always_comb begin
    res_o.status         = status;
    res_o.tag_class      = nxt.class_bits;
    res_o.is_constructed = nxt.constructed;
    res_o.tag_number     = nxt.tag_acc;
    res_o.content_length = nxt.len_acc;
    res_o.header_length  = nxt.hdr_cnt;
    res_o.int_value      = value;
  end

endmodule
`default_nettype wire

### hdl/asn1_der_tag_header_parser.sv
// Top level of the ASN.1 DER tag/length header parser.
// Takes one octet of a DER buffer per transfer and returns one header result
// per item (class, constructed bit, tag number, length, header size and, when
// expect_integer is set, the sign-extended INTEGER value). The parser state and
// the result register are updated at the edge the octet is accepted, so octets
// stream at one per cycle while the input is not stalled, and a result appears
// on the output in the cycle after the octet that completes or breaks its item.
// Input is stalled only while a result is held and the output side stalls.
// After an error the parser drops octets up to and including the octet marked
// last_byte. expect_integer is written through cfg_we_i/cfg_wdata_i; the user
// must write it while no item is in progress; the block does not enforce this.
`default_nettype none
module asn1_der_tag_header_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  asn1hdr_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output asn1hdr_pkg::out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import asn1hdr_pkg::*;

  state_t state_q, state_d;
  logic   expect_q;
  logic   out_valid_q;
  out_t   out_data_q;
  logic   res_valid;
  out_t   res;
  logic   in_xfer;

  // Hold input while a result waits on a stalled output
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  asn1hdr_step u_step (
    .state_i          (state_q),
    .in_i             (in_data_i),
    .expect_integer_i (expect_q),
    .state_o          (state_d),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b0;
    end else if (cfg_we_i) begin
      expect_q <= cfg_wdata_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDENT, default: '0};
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

### dv/asn1_der_tag_header_parser_tb.sv
// Self-checking testbench for the DER tag/length header parser: random DER buffers, scoreboard.
`timescale 1ns / 100ps
module asn1_der_tag_header_parser_tb;
  import asn1hdr_pkg::*;

  localparam int TARGET_OCTETS = 700;
  localparam int N_PHASES      = 6;
  localparam int DRAIN_CYCLES  = 4;

  typedef logic [7:0] octet_q_t[$];

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  bit idle_on      = 1'b1;
  int stall_left   = 0;
  int octets_sent  = 0;
  int buffers_sent = 0;
  int int_phases   = 0;

  asn1_der_tag_header_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Header scoreboard: tracks the parse of the octet stream and holds the
  // header results still owed by the block.
  class header_checker;
    out_t        expected_hdrs[$];
    bit          int_mode;
    phase_e      cur_phase;
    logic [1:0]  cls;
    logic        cons;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [31:0] remaining;
    logic [31:0] int_acc;
    logic [2:0]  oct_cnt;
    logic [3:0]  hdr_cnt;
    int          errors;
    int          headers;
    int          status_cnt[8];

    function new();
      int_mode  = 1'b0;
      cur_phase = PH_IDENT;
      cls       = '0;
      cons      = 1'b0;
      tag_acc   = '0;
      len_acc   = '0;
      remaining = '0;
      int_acc   = '0;
      oct_cnt   = '0;
      hdr_cnt   = '0;
      errors    = 0;
      headers   = 0;
    endfunction

    // Queue one header; a failure not on the marked octet drops the rest of the buffer
    function void post(logic [2:0] st, logic [31:0] value, logic last);
      out_t hdr;
      hdr.status         = st;
      hdr.tag_class      = cls;
      hdr.is_constructed = cons;
      hdr.tag_number     = tag_acc;
      hdr.content_length = len_acc;
      hdr.header_length  = hdr_cnt;
      hdr.int_value      = value;
      expected_hdrs.push_back(hdr);
      cur_phase = (st != ST_OK && !last) ? PH_SKIP : PH_IDENT;
    endfunction

    // Item complete: in integer mode check form, class, type and length, in this priority
    function void close_item(logic last);
      if (!int_mode) post(ST_OK, '0, last);
      else if (cons) post(ST_ENCODING, '0, last);
      else if (cls != CLASS_UNIVERSAL) post(ST_CLASS, '0, last);
      else if (tag_acc != TAG_INTEGER) post(ST_TYPE, '0, last);
      else if (len_acc < 1 || len_acc > MAX_INT_OCTETS) post(ST_TRUNCATED, '0, last);
      else post(ST_OK, int_acc, last);
    endfunction

    function void start_body(logic last);
      remaining = len_acc;
      if (remaining == 0) close_item(last);
      else begin
        cur_phase = PH_BODY;
        if (last) post(ST_TRUNCATED, '0, last);
      end
    endfunction

    // One accepted input transfer
    function void take_octet(in_t x);
      logic [7:0] b;
      logic       last;
      b    = x.data_byte;
      last = x.last_byte;
      case (cur_phase)
        PH_TAG: begin
          hdr_cnt++;
          oct_cnt++;
          tag_acc = {tag_acc[24:0], b[6:0]};
          if (b[7] && oct_cnt >= MAX_TAG_OCTETS) post(ST_TRUNCATED, '0, last);
          else begin
            if (!b[7]) cur_phase = PH_LEN0;
            if (last) post(ST_TRUNCATED, '0, last);
          end
        end
        PH_LEN0: begin
          hdr_cnt++;
          if (!b[7]) begin
            len_acc = {24'd0, b};
            start_body(last);
          end else if (b == LEN_INDEFINITE || b == LEN_RESERVED ||
                       b[6:0] > MAX_LENGTH_OCTETS) begin
            post(ST_TRUNCATED, '0, last);
          end else begin
            oct_cnt   = b[2:0];
            cur_phase = PH_LENL;
            if (last) post(ST_TRUNCATED, '0, last);
          end
        end
        PH_LENL: begin
          hdr_cnt++;
          len_acc = {len_acc[23:0], b};
          if (oct_cnt != 0) oct_cnt--;
          if (oct_cnt == 0) start_body(last);
          else if (last) post(ST_TRUNCATED, '0, last);
        end
        PH_BODY: begin
          // first contents octet is sign-extended, the rest shift in
          if (remaining == len_acc) int_acc = {{24{b[7]}}, b};
          else int_acc = {int_acc[23:0], b};
          if (remaining != 0) remaining--;
          if (remaining == 0) close_item(last);
          else if (last) post(ST_TRUNCATED, '0, last);
        end
        PH_SKIP: begin
          if (last) cur_phase = PH_IDENT;
        end
        default: begin
          cls       = b[7:6];
          cons      = b[5];
          tag_acc   = '0;
          len_acc   = '0;
          remaining = '0;
          int_acc   = '0;
          oct_cnt   = '0;
          hdr_cnt   = 4'd1;
          if (b[4:0] != TAG_HIGH_FORM) begin
            tag_acc   = {27'd0, b[4:0]};
            cur_phase = PH_LEN0;
          end else begin
            cur_phase = PH_TAG;
          end
          if (last) post(ST_TRUNCATED, '0, last);
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // One accepted result transfer against the oldest expected header
    function void compare_header(out_t got);
      out_t want;
      headers++;
      status_cnt[got.status]++;
      if (expected_hdrs.size() == 0) begin
        errors++;
        $display("%0t: header result with none expected, status %0d tag %h", $time,
                 got.status, got.tag_number);
        return;
      end
      want = expected_hdrs.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("tag_class", 32'(want.tag_class), 32'(got.tag_class));
      check_field("is_constructed", 32'(want.is_constructed), 32'(got.is_constructed));
      check_field("tag_number", want.tag_number, got.tag_number);
      check_field("content_length", want.content_length, got.content_length);
      check_field("header_length", 32'(want.header_length), 32'(got.header_length));
      check_field("int_value", want.int_value, got.int_value);
    endfunction
  endclass

  header_checker board;

  always #5 clk = ~clk;

  // Result side: random stall bursts
  always @(negedge clk) begin
    if (idle_on && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.compare_header(out_data);
  end

  // Drive one octet, with an occasional gap ahead of it
  task automatic send_octet(input logic [7:0] b, input logic last);
    in_t x;
    x.data_byte = b;
    x.last_byte = last;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_octet(x);
    octets_sent++;
  endtask

  task automatic send_buffer(input octet_q_t q);
    for (int i = 0; i < q.size(); i++) send_octet(q[i], i == q.size() - 1);
    buffers_sent++;
  endtask

  // Stop sending and wait until every owed header has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_hdrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_int_mode(input bit on);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = on;
    @(posedge clk);
    board.int_mode = on;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Append one TLV item; returns 1 when the item swallows the rest of the buffer
  function automatic bit add_item(ref octet_q_t q, input bit int_bias);
    logic [7:0]  id;
    logic [7:0]  b;
    logic [31:0] lv;
    int          n_tag;
    int          n_len;
    int          clen;
    bit          too_long;
    bit          neg;
    id = 8'($urandom);
    if (int_bias && $urandom_range(0, 3) != 0) id = {CLASS_UNIVERSAL, 1'b0, TAG_INTEGER[4:0]};
    else if ($urandom_range(0, 5) == 0) id[4:0] = TAG_HIGH_FORM;
    q.push_back(id);

    // high tag form, sometimes one continuation octet too many
    if (id[4:0] == TAG_HIGH_FORM) begin
      too_long = ($urandom_range(0, 7) == 0);
      n_tag    = too_long ? MAX_TAG_OCTETS : $urandom_range(1, MAX_TAG_OCTETS);
      for (int i = 0; i < n_tag; i++) begin
        b    = 8'($urandom);
        b[7] = (i < n_tag - 1) || too_long;
        q.push_back(b);
      end
      if (too_long) return 1'b1;
    end

    // illegal length octet
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0:       q.push_back(LEN_INDEFINITE);
        1:       q.push_back(LEN_RESERVED);
        default: q.push_back(8'($urandom_range(LEN_INDEFINITE + MAX_LENGTH_OCTETS + 1, 8'hFE)));
      endcase
      return 1'b1;
    end

    // huge long-form length; the buffer ends inside the contents when that length exceeds the octets after it
    if ($urandom_range(0, 15) == 0) begin
      lv = $urandom;
      q.push_back(8'h80 | 8'(MAX_LENGTH_OCTETS));
      for (int i = MAX_LENGTH_OCTETS - 1; i >= 0; i--) q.push_back(lv[8*i +: 8]);
      repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
      return 1'b1;
    end

    if (int_bias) clen = $urandom_range(0, MAX_INT_OCTETS + 1);
    else if ($urandom_range(0, 24) == 0) clen = $urandom_range(128, 300);
    else clen = $urandom_range(0, 8);

    // short form, or long form with leading zero octets allowed
    if (clen > 127 || $urandom_range(0, 3) == 0) begin
      n_len = (clen > 255) ? $urandom_range(2, MAX_LENGTH_OCTETS)
                           : $urandom_range(1, MAX_LENGTH_OCTETS);
      lv    = clen;
      q.push_back(8'h80 | 8'(n_len));
      for (int i = n_len - 1; i >= 0; i--) q.push_back(lv[8*i +: 8]);
    end else begin
      q.push_back(8'(clen));
    end

    // contents; four-octet payloads are often pushed to the 32-bit extremes
    neg = 1'($urandom_range(0, 1));
    for (int i = 0; i < clen; i++) begin
      b = 8'($urandom);
      if (clen == MAX_INT_OCTETS && $urandom_range(0, 2) == 0)
        b = (i == 0) ? {neg, {7{~neg}}} : {8{~neg}};
      q.push_back(b);
    end
    return 1'b0;
  endfunction

  function automatic void build_buffer(ref octet_q_t q, input bit int_bias);
    int n_items;
    int cut;
    q.delete();
    // line noise
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
      return;
    end
    n_items = $urandom_range(1, 4);
    for (int i = 0; i < n_items; i++) begin
      if (add_item(q, int_bias)) break;
    end
    // buffer cut short
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, q.size());
      q   = q[0:cut-1];
    end
  endfunction

  // Stimulus
  initial begin
    octet_q_t octets;
    bit       int_on;
    board = new();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // buffer ends right after the identifier octet
    octets = '{8'hC0};
    send_buffer(octets);
    // high tag form one octet too long, rest dropped up to the marked octet
    octets = '{8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_buffer(octets);
    // indefinite length
    octets = '{8'h04, 8'h80, 8'h00};
    send_buffer(octets);
    // reserved length octet on the marked octet
    octets = '{8'h04, 8'hFF};
    send_buffer(octets);
    // long form with more length octets than allowed
    octets = '{8'h04, 8'h85, 8'h00};
    send_buffer(octets);
    // maximum length, buffer ends in the contents
    octets = '{8'h30, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAB};
    send_buffer(octets);
    // private class, five-octet tag that wraps, zero length
    octets = '{8'hDF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    send_buffer(octets);

    // random phases, integer mode alternating; the last one without idling
    for (int p = 0; p < N_PHASES; p++) begin
      int_on = (p % 2 == 0);
      if (p == N_PHASES - 1) idle_on = 1'b0;
      set_int_mode(int_on);
      if (int_on) int_phases++;
      while (octets_sent < (p + 1) * TARGET_OCTETS / N_PHASES) begin
        build_buffer(octets, int_on ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0));
        send_buffer(octets);
        // now and then hold the input until all owed headers are back
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end
    wait_idle();

    $display("Run covered %0d octets in %0d buffers, %0d header results compared (%0d ok).",
             octets_sent, buffers_sent, board.headers, board.status_cnt[ST_OK]);
    $display("Errors: %0d invalid, %0d encoding, %0d class, %0d type; %0d integer-mode phases.",
             board.status_cnt[ST_TRUNCATED], board.status_cnt[ST_ENCODING],
             board.status_cnt[ST_CLASS], board.status_cnt[ST_TYPE], int_phases);
    if (board.errors == 0 && board.expected_hdrs.size() == 0) begin
      $display("** asn1_der_tag_header_parser: PASSED **");
    end else begin
      $display("** asn1_der_tag_header_parser: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("%0t: timeout, %0d headers still owed", $time, board.expected_hdrs.size());
    $display("** asn1_der_tag_header_parser: FAILED **");
    $finish;
  end

endmodule
